[rtl/chd_pkg.sv]
// Package for the chunked transfer decoder: payload structs, phase and
// status codes, character constants and the hex digit decode function.
// No dependencies.
package chd_pkg;

    localparam int LenBits = 32;
    localparam int OutLenBits = 32;

    localparam logic [7:0] ChCr = 8'h0D;
    localparam logic [7:0] ChLf = 8'h0A;
    localparam logic [7:0] ChZero = 8'h30;
    localparam logic [7:0] ChNine = 8'h39;
    localparam logic [7:0] ChLowA = 8'h61;
    localparam logic [7:0] ChLowF = 8'h66;
    localparam logic [7:0] ChUpA = 8'h41;
    localparam logic [7:0] ChUpF = 8'h46;
    localparam logic [3:0] DigitTen = 4'd10;

    typedef logic [LenBits-1:0] len_t;

    typedef enum logic [6:0] {
        PH_SIZE     = 7'b0000001,
        PH_EXT      = 7'b0000010,
        PH_SIZE_LF  = 7'b0000100,
        PH_DATA     = 7'b0001000,
        PH_TRAIL_CR = 7'b0010000,
        PH_TRAIL_LF = 7'b0100000,
        PH_DONE     = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic                  payload_valid;
        logic [7:0]            payload_byte;
        logic [1:0]            status;
        logic [OutLenBits-1:0] decoded_length;
    } out_item_t;

    typedef struct packed {
        logic       hex;
        logic [3:0] value;
    } hex_digit_t;

    function automatic hex_digit_t hex_decode(input logic [7:0] b);
        hex_digit_t r;
        r.hex = 1'b1;
        r.value = 4'd0;
        if (b inside {[ChZero:ChNine]}) begin
            r.value = 4'(b - ChZero);
        end else if (b inside {[ChLowA:ChLowF]}) begin
            r.value = 4'(b - ChLowA) + DigitTen;
        end else if (b inside {[ChUpA:ChUpF]}) begin
            r.value = 4'(b - ChUpA) + DigitTen;
        end else begin
            r.hex = 1'b0;
        end
        return r;
    endfunction

endpackage

[rtl/chd_in_if.sv]
// Input channel of the chunked transfer decoder: valid/ready and one
// encoded byte with its last-byte mark. Depends on chd_pkg.
interface chd_in_if;
    logic             valid;
    logic             ready;
    chd_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/chd_out_if.sv]
// Output channel of the chunked transfer decoder: valid/ready and one
// result item. Depends on chd_pkg.
interface chd_out_if;
    logic              valid;
    logic              ready;
    chd_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/http_chunked_decoder_unit.sv]
// HTTP chunked transfer decoder top level. Depends on chd_pkg, chd_in_if, chd_out_if.
// Results are registered: a result is presented in the cycle after its byte is accepted.
// One byte per cycle while no result stalls; phase and counters update once per byte.
// The result register frees in the cycle its request is taken downstream.
// Reset: rst_n asynchronous, active low; clears phase, counters and the
// result valid flag.
module http_chunked_decoder_unit (
    input  logic      clk,
    input  logic      rst_n,
    chd_in_if.sink    body,
    chd_out_if.source decoded
);

    chd_pkg::phase_t    phase_reg, phase_next;
    chd_pkg::len_t      acc_reg, acc_next;
    chd_pkg::len_t      left_reg, left_next;
    chd_pkg::len_t      total_reg, total_next;
    logic               out_valid_reg, out_valid_next;
    chd_pkg::out_item_t out_data_reg, out_data_next;

    logic               accept;
    logic               do_data;
    logic               do_size;
    logic               has_result;
    logic [7:0]         b;
    logic               eoi;
    chd_pkg::hex_digit_t hd;
    chd_pkg::status_t   st;
    logic               res_valid;
    logic [7:0]         res_byte;

    assign body.ready = !out_valid_reg || decoded.ready;
    assign accept = body.valid && body.ready;
    assign b = body.payload.data_byte;
    assign eoi = body.payload.end_of_input;
    assign hd = chd_pkg::hex_decode(b);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next = acc_reg;
        left_next = left_reg;
        total_next = total_reg;
        do_data = 1'b0;
        do_size = 1'b0;
        st = chd_pkg::ST_RUN;
        res_valid = 1'b0;
        res_byte = 8'd0;

        case (phase_reg)
            chd_pkg::PH_DONE:
            begin
            end
            chd_pkg::PH_SIZE_LF:
            begin
                if (b == chd_pkg::ChLf) phase_next = chd_pkg::PH_DATA;
                else do_data = 1'b1;
            end
            chd_pkg::PH_DATA:
            begin
                do_data = 1'b1;
            end
            chd_pkg::PH_TRAIL_CR:
            begin
                if (b == chd_pkg::ChCr) begin
                    phase_next = chd_pkg::PH_TRAIL_LF;
                end else begin
                    phase_next = chd_pkg::PH_SIZE;
                    do_size = (b != chd_pkg::ChLf);
                end
            end
            chd_pkg::PH_TRAIL_LF:
            begin
                phase_next = chd_pkg::PH_SIZE;
                do_size = (b != chd_pkg::ChLf);
            end
            chd_pkg::PH_SIZE, chd_pkg::PH_EXT:
            begin
                do_size = 1'b1;
            end
            default:
            begin
                phase_next = chd_pkg::PH_SIZE;
                do_size = 1'b1;
            end
        endcase

        if (do_data) begin
            res_valid = 1'b1;
            res_byte = b;
            total_next = total_reg + chd_pkg::len_t'(1);
            left_next = left_reg - chd_pkg::len_t'(1);
            phase_next = (left_next == '0) ? chd_pkg::PH_TRAIL_CR : chd_pkg::PH_DATA;
        end

        if (do_size) begin
            if (b == chd_pkg::ChCr || b == chd_pkg::ChLf) begin
                if (acc_reg == '0) begin
                    st = chd_pkg::ST_DONE;
                    phase_next = chd_pkg::PH_DONE;
                end else begin
                    left_next = acc_reg;
                    acc_next = '0;
                    phase_next = (b == chd_pkg::ChCr) ? chd_pkg::PH_SIZE_LF
                                                      : chd_pkg::PH_DATA;
                end
            end else if (phase_next != chd_pkg::PH_EXT) begin
                if (hd.hex) acc_next = {acc_reg[chd_pkg::LenBits-5:0], hd.value};
                else phase_next = chd_pkg::PH_EXT;
            end
        end

        // settle the status on the last byte of the body
        if (eoi && phase_reg != chd_pkg::PH_DONE && st == chd_pkg::ST_RUN) begin
            if (phase_next == chd_pkg::PH_SIZE_LF || phase_next == chd_pkg::PH_DATA)
                st = chd_pkg::ST_ERR;
            else if ((phase_next == chd_pkg::PH_SIZE || phase_next == chd_pkg::PH_EXT)
                     && acc_next != '0)
                st = chd_pkg::ST_ERR;
            else
                st = chd_pkg::ST_DONE;
        end

        out_data_next.payload_valid = res_valid;
        out_data_next.payload_byte = res_byte;
        out_data_next.status = st;
        out_data_next.decoded_length = (st == chd_pkg::ST_DONE)
            ? chd_pkg::OutLenBits'(total_next) : '0;
        has_result = res_valid || (st != chd_pkg::ST_RUN);

        if (eoi) begin
            phase_next = chd_pkg::PH_SIZE;
            acc_next = '0;
            left_next = '0;
            total_next = '0;
        end

        if (accept && has_result) out_valid_next = 1'b1;
        else if (decoded.ready) out_valid_next = 1'b0;
        else out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= chd_pkg::PH_SIZE;
            acc_reg <= '0;
            left_reg <= '0;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                phase_reg <= phase_next;
                acc_reg <= acc_next;
                left_reg <= left_next;
                total_reg <= total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_result) out_data_reg <= out_data_next;
    end

    assign decoded.valid = out_valid_reg;
    assign decoded.payload = out_data_reg;

    // hold the input while a result waits downstream
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !decoded.ready |-> !body.ready)
        else $error("input taken while result stalled");

    a_eoi_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && eoi |=> phase_reg == chd_pkg::PH_SIZE && acc_reg == '0
                          && left_reg == '0 && total_reg == '0)
        else $error("state not cleared after last byte");

    a_error_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status != chd_pkg::ST_DONE
        |-> out_data_reg.decoded_length == '0)
        else $error("length reported without completion");

    a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.payload_valid
                          || out_data_reg.status != chd_pkg::ST_RUN)
        else $error("empty result presented");

    a_done_phase_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == chd_pkg::PH_DONE |=> !out_valid_reg || $stable(out_data_reg))
        else $error("result produced after completion");

endmodule
